@@ rtl/core/sha256_stream_hasher_core_macros.svh @@
// Assertion macros shared by the hasher RTL
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define SHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/shs_pkg.sv @@
package shs_pkg;

	localparam int unsigned RoundCount = 64;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned PadLenPos  = 56;
	localparam logic [7:0]  PadMarker  = 8'h80;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the compression unit
	typedef struct packed {
		logic       start;
		logic       round_en;
		logic [5:0] round;
		logic       fold;
		logic       init;
	} cmp_ctrl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		logic [31:0] k [0:63];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		round_k = k[i];
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		logic [31:0] h [0:7];
		h = '{
			32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
		};
		init_h = h[i];
	endfunction

endpackage

@@ rtl/core/shs_if.sv @@
interface shs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, byte_value, has_byte, end_of_message, input ready);
	modport sink (input valid, byte_value, has_byte, end_of_message, output ready);
endinterface

interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/shs_compress.sv @@
module shs_compress (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shs_pkg::cmp_ctrl_t    ctrl,
	input  shs_pkg::word_t        msg_word,
	input  logic [2:0]            hash_sel,
	output shs_pkg::word_t        hash_word
);
	import shs_pkg::*;

	word_t hash_q [0:7];
	word_t r_q [0:7];
	word_t sched_q [0:15];

	word_t w, s0, s1, w15, w2, t1, t2;
	logic [3:0] ri;

	// Form the schedule word: first sixteen rounds take message words
	always_comb begin
		ri  = ctrl.round[3:0];
		w15 = sched_q[4'(ri + 4'd1)];
		w2  = sched_q[4'(ri + 4'd14)];
		s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		if (ctrl.round < 6'd16) begin
			w = msg_word;
		end else begin
			w = s1 + sched_q[4'(ri + 4'd9)] + s0 + sched_q[ri];
		end
		t1 = r_q[7] + (rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25))
			+ ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + round_k(ctrl.round) + w;
		t2 = (rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22))
			+ ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
	end

	// Advance one round per cycle while round_en is set
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < 8; i++) r_q[i] <= hash_q[i];
		end else if (ctrl.round_en) begin
			sched_q[ri] <= w;
			r_q[7] <= r_q[6];
			r_q[6] <= r_q[5];
			r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + t1;
			r_q[3] <= r_q[2];
			r_q[2] <= r_q[1];
			r_q[1] <= r_q[0];
			r_q[0] <= t1 + t2;
		end
	end

	// Hold chained hash, fold at block end, reload at message end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
		end else if (ctrl.init) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + r_q[i];
		end
	end

	assign hash_word = hash_q[hash_sel];

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// SHA-256 over a byte stream, one byte per input word. Bytes land in a
// 64-byte block memory (one write and one 32-bit read a cycle, read data
// registered). A full block runs 64 compression rounds at one round a cycle
// with the input held off, in the order load, 64 rounds, fold. On end of
// message the padding is written into the block memory one word a cycle (all
// sixteen words each pass), one or two blocks are compressed, then eight
// digest words are sent, hash word 0 first; the hash is reloaded for the next
// message. No clearing pass.
`include "sha256_stream_hasher_core_macros.svh"
module sha256_stream_hasher_core (
	input logic clk,
	input logic arst_n,
	shs_in_if.sink   in_ch,
	shs_out_if.source out_ch
);
	import shs_pkg::*;

	// Block memory as sixteen 32-bit words with byte enables
	logic [31:0] mem [0:15];
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [3:0]  mem_be;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	logic [31:0] mem_rdata_q;

	state_t      state_q, state_d;
	logic [5:0]  cnt_q;
	logic [5:0]  bytes_q;
	logic [63:0] bitlen_q;
	logic        end_q;      // message ends, digest follows the last block
	logic        two_q;      // length block still to come
	logic        zero_q;     // pass of zeros and length only
	logic        pend_q;
	logic [63:0] padlen_q;
	logic [3:0]  pad_idx_q;
	cmp_ctrl_t   ctrl;
	word_t       hash_word;
	logic        acc;

	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int b = 0; b < 4; b++)
				if (mem_be[b]) mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// Pad word: marker, zeros and length by byte position
	logic [31:0] pad_word;
	always_comb begin
		pad_word = '0;
		for (int b = 0; b < 4; b++) begin
			logic [5:0] pos;
			pos = {pad_idx_q, 2'(3 - b)};
			if (!two_q && pos >= 6'(PadLenPos)) begin
				pad_word[8*b +: 8] = padlen_q[8*(63 - pos) +: 8];
			end else if (zero_q) begin
				pad_word[8*b +: 8] = 8'h00;
			end else if (pos == bytes_q) begin
				pad_word[8*b +: 8] = PadMarker;
			end
		end
	end

	// Memory access steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bytes_q[5:2];
		mem_be    = '0;
		mem_wdata = {4{in_ch.byte_value}};
		mem_raddr = (state_q == ST_ROUND) ? 4'(cnt_q[3:0] + 4'd1) : cnt_q[3:0];
		if (state_q == ST_IDLE && acc && in_ch.has_byte) begin
			mem_we = 1'b1;
			mem_be = 4'b1000 >> bytes_q[1:0];
		end else if (state_q == ST_PAD) begin
			mem_we    = 1'b1;
			mem_waddr = pad_idx_q;
			mem_wdata = pad_word;
			for (int b = 0; b < 4; b++)
				mem_be[b] = ({pad_idx_q, 2'(3 - b)} >= bytes_q) || zero_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_ch.has_byte && bytes_q == 6'(BlockBytes - 1))
						state_d = ST_LOAD;
					else if (in_ch.end_of_message)
						state_d = ST_PAD;
				end
			end
			ST_PAD:   if (pad_idx_q == 4'd15) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 6'(RoundCount - 1)) state_d = ST_FOLD;
			ST_FOLD: begin
				if (two_q || pend_q) state_d = ST_PAD;
				else if (end_q) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_EMIT:  if (out_ch.ready && cnt_q[2:0] == 3'd7) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Compression unit controls
	always_comb begin
		ctrl          = '0;
		ctrl.start    = (state_q == ST_LOAD);
		ctrl.round_en = (state_q == ST_ROUND);
		ctrl.round    = cnt_q;
		ctrl.fold     = (state_q == ST_FOLD);
		ctrl.init     = (state_q == ST_EMIT) && out_ch.ready && cnt_q[2:0] == 3'd7;
	end

	// Advance counters, length and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			bytes_q   <= '0;
			bitlen_q  <= '0;
			end_q     <= 1'b0;
			two_q     <= 1'b0;
			zero_q    <= 1'b0;
			padlen_q  <= '0;
			pad_idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					pad_idx_q <= '0;
					if (acc) begin
						logic [5:0] nb;
						nb = in_ch.has_byte ? 6'(bytes_q + 6'd1) : bytes_q;
						if (in_ch.has_byte) bytes_q <= nb;
						end_q <= in_ch.end_of_message;
						if (in_ch.has_byte && bytes_q == 6'(BlockBytes - 1)) begin
							bitlen_q <= bitlen_q + 64'd512;
							padlen_q <= bitlen_q + 64'd512;
							two_q    <= 1'b0;
						end else begin
							padlen_q <= bitlen_q + {55'd0, nb, 3'd0};
							two_q    <= (nb >= 6'(PadLenPos));
						end
					end
				end
				ST_PAD: pad_idx_q <= 4'(pad_idx_q + 4'd1);
				ST_LOAD: cnt_q <= '0;
				ST_ROUND: cnt_q <= 6'(cnt_q + 6'd1);
				ST_FOLD: begin
					cnt_q     <= '0;
					pad_idx_q <= '0;
					if (two_q) begin
						two_q  <= 1'b0;
						zero_q <= 1'b1;
					end else begin
						zero_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						cnt_q <= 6'(cnt_q + 6'd1);
						if (cnt_q[2:0] == 3'd7) begin
							bytes_q  <= '0;
							bitlen_q <= '0;
							end_q    <= 1'b0;
						end
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// Full block arriving with end: pad after the data block compresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (state_q == ST_IDLE && acc)
			pend_q <= in_ch.has_byte && bytes_q == 6'(BlockBytes - 1) && in_ch.end_of_message;
		else if (state_q == ST_FOLD) pend_q <= 1'b0;
	end

	// Round words: the memory read is registered and issued in the cycle before use
	word_t msg_word;
	assign msg_word = mem_rdata_q;

	shs_compress u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.msg_word  (msg_word),
		.hash_sel  (cnt_q[2:0]),
		.hash_word (hash_word)
	);

	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.digest_word = hash_word;
	assign out_ch.word_index  = cnt_q[2:0];
	assign out_ch.last_word   = (cnt_q[2:0] == 3'd7);

	`SHS_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_ch.ready, "input taken while busy")
	`SHS_ASSERT_IMP(a_last_idx, clk, arst_n, out_ch.valid && out_ch.last_word, out_ch.word_index == 3'd7, "last word misplaced")
	`SHS_ASSERT_NXT(a_round_chain, clk, arst_n, state_q == ST_LOAD, state_q == ST_ROUND, "rounds did not start")
	`SHS_ASSERT_NXT(a_emit_done, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.last_word, state_q == ST_IDLE, "emit did not finish")

endmodule

@@ test/sha256_hasher_checker.sv @@
`timescale 1ns / 1ps
module sha256_hasher_checker (
	input  logic      clk,
	input  logic      arst_n,
	shs_in_if         in_ch,
	shs_out_if        out_ch,
	output int        mismatch_count,
	output int        pending_words
);
	import shs_pkg::*;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	localparam logic [31:0] HashInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [7:0]   blk [64];
	logic [6:0]   fill;
	logic [63:0]  bit_len;
	logic [31:0]  hv [8];
	digest_item_t digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// run the 64 rounds over the buffered block and fold into the chain
	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] r [8];
		logic [31:0] wv, t1, t2, a, b;
		for (int i = 0; i < 8; i++) r[i] = hv[i];
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				wv = w[i];
			end else begin
				a = w[(i-15)&15];
				b = w[(i-2)&15];
				wv = (ror(b,17)^ror(b,19)^(b>>10)) + w[(i-7)&15]
					+ (ror(a,7)^ror(a,18)^(a>>3)) + w[i&15];
				w[i&15] = wv;
			end
			t1 = r[7] + (ror(r[4],6)^ror(r[4],11)^ror(r[4],25))
				+ ((r[4]&r[5])^(~r[4]&r[6])) + RoundConst[i] + wv;
			t2 = (ror(r[0],2)^ror(r[0],13)^ror(r[0],22))
				+ ((r[0]&r[1])^(r[0]&r[2])^(r[1]&r[2]));
			r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
			r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hv[i] += r[i];
	endtask

	task automatic restart();
		fill = 0;
		bit_len = 0;
		for (int i = 0; i < 8; i++) hv[i] = HashInit[i];
	endtask

	// absorb one input word, pad and queue the digest on end of message
	task automatic absorb_word(input logic [7:0] bv, input logic hb, input logic eom);
		int n;
		logic [63:0] len;
		digest_item_t d;
		if (hb) begin
			blk[fill[5:0]] = bv;
			fill++;
			if (fill >= 64) begin
				compress();
				bit_len += 512;
				fill = 0;
			end
		end
		if (eom) begin
			n = fill[5:0];
			len = bit_len + 64'(n) * 8;
			blk[n] = 8'h80;
			for (int i = n + 1; i < 64; i++) blk[i] = 0;
			if (n >= 56) begin
				compress();
				for (int i = 0; i < 56; i++) blk[i] = 0;
			end
			for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hv[i];
				d.word_index  = 3'(i);
				d.last_word   = (i == 7);
				digest_q.push_back(d);
			end
			restart();
		end
	endtask

	assign pending_words = digest_q.size();

	// watch both channels at the rising edge
	always @(posedge clk) begin
		digest_item_t exp_d, got;
		if (!arst_n) begin
			restart();
			digest_q.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				absorb_word(in_ch.byte_value, in_ch.has_byte, in_ch.end_of_message);
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.digest_word, out_ch.word_index, out_ch.last_word};
				if (digest_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected digest word %h idx %0d last %0d",
							got.digest_word, got.word_index, got.last_word);
				end else begin
					exp_d = digest_q.pop_front();
					if (got !== exp_d) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
								exp_d.digest_word, exp_d.word_index, exp_d.last_word,
								got.digest_word, got.word_index, got.last_word);
					end
				end
			end
		end
	end
endmodule

@@ test/tb_sha256_stream_hasher_core.sv @@
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_core;
	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending_words;
	int   cycle_count;
	bit   stim_done;
	bit   hold_sink;

	shs_in_if  in_ch ();
	shs_out_if out_ch ();

	sha256_stream_hasher_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sha256_hasher_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.mismatch_count (mismatch_count),
		.pending_words  (pending_words)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// offer one word and hold it until accepted
	task automatic send_word(input logic [7:0] bv, input logic hb, input logic eom);
		int g;
		g = gap_len();
		repeat (g) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.byte_value     <= bv;
		in_ch.has_byte       <= hb;
		in_ch.end_of_message <= eom;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input logic end_with_byte);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom), 1'b1, end_with_byte && i == len - 1);
		if (!end_with_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	// stimulus
	initial begin
		int len;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.byte_value = '0;
		in_ch.has_byte = 1'b0;
		in_ch.end_of_message = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		// empty message, byte ignored, extremes with end
		send_word(8'hff, 1'b0, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hff, 1'b1, 1'b1);
		send_word(8'h5a, 1'b0, 1'b0);
		send_word(8'ha5, 1'b1, 1'b0);
		send_word(8'h3c, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		// padding that spills into an extra block
		send_message(56, 1'b1);
		send_message(63, 1'b0);
		send_message(64, 1'b1);
		// random messages with stray idle words
		while (in_ch.valid !== 1'bx && len < 170) begin
			int m;
			m = $urandom_range(0, 9) == 0 ? $urandom_range(55, 130) : $urandom_range(0, 20);
			if ($urandom_range(0, 4) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_message(m, 1'($urandom));
			len += m + 1;
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// long hold-off once early in the run
	initial begin
		hold_sink = 1'b0;
		#600;
		@(negedge clk);
		hold_sink = 1'b1;
		repeat (400) @(negedge clk);
		hold_sink = 1'b0;
	end

	// receiver with random stalls
	initial begin
		int g;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_ch.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	// run limit and verdict
	initial begin
		cycle_count = 0;
		while (!(stim_done && pending_words == 0) && cycle_count < 400000) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= 400000) begin
			$display("end of test: mismatches");
		end else begin
			repeat (200) @(posedge clk);
			if (mismatch_count == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
